>>> sv/wbs_pkg.sv
package wbs_pkg;

	localparam int OUT_W = 20;
	localparam int SLOT_N = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int SLOT_W = $clog2(SLOT_N + 1);

	typedef struct packed {
		logic [OUT_W-1:0] start_idx;
		logic [OUT_W-1:0] end_idx;
		logic             word;
		logic             last;
		logic             wrapped;
	} seg_t;

	// one accepted item's worth of results, count of 0..3 valid slots
	typedef struct packed {
		logic [SLOT_W-1:0]     count;
		seg_t [SLOT_N-1:0]     seg;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/wbs_front.sv
module wbs_front #(
	parameter int INDEX_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [4:0]          word_class,
	input  logic                starts_word,
	input  logic                end_of_text,
	input  wbs_pkg::q_stat_t    q_stat,
	output logic                push,
	output wbs_pkg::entry_t     push_entry
);

	localparam logic [4:0] C_OTHER     = 5'd0;
	localparam logic [4:0] C_CR        = 5'd1;
	localparam logic [4:0] C_LF        = 5'd2;
	localparam logic [4:0] C_NL        = 5'd3;
	localparam logic [4:0] C_EXTEND    = 5'd4;
	localparam logic [4:0] C_FORMAT    = 5'd5;
	localparam logic [4:0] C_KATA      = 5'd6;
	localparam logic [4:0] C_ALETTER   = 5'd7;
	localparam logic [4:0] C_HEBREW    = 5'd8;
	localparam logic [4:0] C_MIDLETTER = 5'd9;
	localparam logic [4:0] C_MIDNUM    = 5'd10;
	localparam logic [4:0] C_MIDNUMLET = 5'd11;
	localparam logic [4:0] C_SQUOTE    = 5'd12;
	localparam logic [4:0] C_DQUOTE    = 5'd13;
	localparam logic [4:0] C_NUMERIC   = 5'd14;
	localparam logic [4:0] C_ENL       = 5'd15;
	localparam logic [4:0] C_RI        = 5'd16;
	localparam logic [4:0] C_SOT       = 5'd17;
	localparam logic [4:0] C_EOT       = 5'd18;
	localparam logic [4:0] C_NONE      = 5'd19;
	localparam logic [4:0] C_LEAD      = 5'd20;

	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_LEFT  = 2'd1;
	localparam logic [1:0] PEND_BOTH  = 2'd2;

	localparam logic [wbs_pkg::SLOT_W-1:0] ONE_RES = wbs_pkg::SLOT_W'(1);

	function automatic logic is_ah(input logic [4:0] c);
		return (c == C_ALETTER) || (c == C_HEBREW);
	endfunction

	function automatic logic is_mnlq(input logic [4:0] c);
		return (c == C_MIDNUMLET) || (c == C_SQUOTE);
	endfunction

	function automatic logic is_nl(input logic [4:0] c);
		return (c == C_CR) || (c == C_LF) || (c == C_NL);
	endfunction

	function automatic logic is_enlp(input logic [4:0] c);
		return is_ah(c) || (c == C_NUMERIC) || (c == C_KATA) || (c == C_ENL);
	endfunction

	// no boundary between units l and r
	function automatic logic joins(input logic [4:0] lb, input logic [4:0] l,
			input logic [4:0] r, input logic [4:0] la);
		logic j;
		if (l == C_CR && r == C_LF) j = 1'b1;
		else if (is_nl(l) || is_nl(r)) j = 1'b0;
		else j = (is_ah(l) && is_ah(r))
			|| (is_ah(l) && (r == C_MIDLETTER || is_mnlq(r)) && is_ah(la))
			|| (is_ah(lb) && (l == C_MIDLETTER || is_mnlq(l)) && is_ah(r))
			|| (l == C_HEBREW && r == C_SQUOTE)
			|| (l == C_HEBREW && r == C_DQUOTE && la == C_HEBREW)
			|| (lb == C_HEBREW && l == C_DQUOTE && r == C_HEBREW)
			|| (l == C_NUMERIC && r == C_NUMERIC)
			|| (is_ah(l) && r == C_NUMERIC)
			|| (l == C_NUMERIC && is_ah(r))
			|| (lb == C_NUMERIC && (l == C_MIDNUM || is_mnlq(l)) && r == C_NUMERIC)
			|| (l == C_NUMERIC && (r == C_MIDNUM || is_mnlq(r)) && la == C_NUMERIC)
			|| (l == C_KATA && r == C_KATA)
			|| (is_enlp(l) && r == C_ENL)
			|| (l == C_ENL && is_enlp(r))
			|| (l == C_RI && r == C_RI);
		return j;
	endfunction

	function automatic logic [wbs_pkg::OUT_W-1:0] out_idx(input logic [INDEX_BITS-1:0] x);
		logic [wbs_pkg::OUT_W+INDEX_BITS-1:0] wide;
		wide = {{wbs_pkg::OUT_W{1'b0}}, x};
		return wide[wbs_pkg::OUT_W-1:0];
	endfunction

	logic [INDEX_BITS-1:0] pos_q, left_end_q, right_end_q, seg_begin_q;
	logic [4:0]            lb_q, left_q, right_q;
	logic                  seg_word_q, right_word_q, wrap_q;
	logic [1:0]            pend_q;

	logic [INDEX_BITS-1:0] n_pos, n_left_end, n_right_end, n_seg_begin;
	logic [4:0]            n_lb, n_left, n_right;
	logic                  n_seg_word, n_right_word, n_wrap;
	logic [1:0]            n_pend;
	wbs_pkg::entry_t       ent;
	logic [4:0]            wc;
	logic                  accept;

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;
	assign wc = (word_class > C_RI) ? C_OTHER : word_class;

	always_comb begin
		n_pos = pos_q;
		n_left_end = left_end_q;
		n_right_end = right_end_q;
		n_seg_begin = seg_begin_q;
		n_lb = lb_q;
		n_left = left_q;
		n_right = right_q;
		n_seg_word = seg_word_q;
		n_right_word = right_word_q;
		n_wrap = wrap_q;
		n_pend = pend_q;
		ent = '0;

		if (wc == C_EXTEND || wc == C_FORMAT) begin
			// fold into the open unit; leading ones open the segment
			if (pend_q == PEND_NONE) begin
				if (left_q != C_LEAD) begin
					n_seg_word = starts_word;
					n_seg_begin = pos_q;
					n_left = C_LEAD;
				end
			end else if (pend_q == PEND_LEFT) begin
				n_left_end = pos_q;
			end else begin
				n_right_end = pos_q;
			end
		end else if (pend_q == PEND_NONE) begin
			if (left_q != C_LEAD) begin
				n_seg_word = starts_word;
				n_seg_begin = pos_q;
			end
			n_lb = C_SOT;
			n_left = wc;
			n_left_end = pos_q;
			n_pend = PEND_LEFT;
		end else if (pend_q == PEND_LEFT) begin
			n_right = wc;
			n_right_end = pos_q;
			n_right_word = starts_word;
			n_pend = PEND_BOTH;
		end else begin
			if (!joins(lb_q, left_q, right_q, wc)) begin
				ent.seg[0] = '{out_idx(seg_begin_q), out_idx(left_end_q), seg_word_q,
					1'b0, wrap_q};
				ent.count = ONE_RES;
				n_seg_begin = left_end_q + 1'b1;
				n_seg_word = right_word_q;
				n_lb = C_SOT;
			end else begin
				n_lb = left_q;
			end
			n_left = right_q;
			n_left_end = right_end_q;
			n_right = wc;
			n_right_end = pos_q;
			n_right_word = starts_word;
		end

		if (end_of_text) begin
			if (n_pend == PEND_NONE) begin
				ent.seg[ent.count] = '{out_idx(n_seg_begin), out_idx(pos_q), n_seg_word,
					1'b1, wrap_q};
				ent.count = ent.count + ONE_RES;
			end else if (n_pend == PEND_LEFT) begin
				ent.seg[ent.count] = '{out_idx(n_seg_begin), out_idx(n_left_end),
					n_seg_word, 1'b1, wrap_q};
				ent.count = ent.count + ONE_RES;
			end else if (!joins(n_lb, n_left, n_right, C_EOT)) begin
				ent.seg[ent.count] = '{out_idx(n_seg_begin), out_idx(n_left_end),
					n_seg_word, 1'b0, wrap_q};
				ent.count = ent.count + ONE_RES;
				ent.seg[ent.count] = '{out_idx(n_left_end + 1'b1), out_idx(n_right_end),
					n_right_word, 1'b1, wrap_q};
				ent.count = ent.count + ONE_RES;
			end else begin
				ent.seg[ent.count] = '{out_idx(n_seg_begin), out_idx(n_right_end),
					n_seg_word, 1'b1, wrap_q};
				ent.count = ent.count + ONE_RES;
			end
			// next item opens a new text
			n_pos = '0;
			n_left_end = '0;
			n_right_end = '0;
			n_seg_begin = '0;
			n_lb = C_SOT;
			n_left = C_SOT;
			n_right = C_NONE;
			n_seg_word = 1'b0;
			n_right_word = 1'b0;
			n_pend = PEND_NONE;
			n_wrap = 1'b0;
		end else begin
			n_pos = pos_q + 1'b1;
			if (n_pos == '0) n_wrap = 1'b1;
		end
	end

	assign push = accept && (ent.count != '0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			left_end_q <= '0;
			right_end_q <= '0;
			seg_begin_q <= '0;
			lb_q <= C_SOT;
			left_q <= C_SOT;
			right_q <= C_NONE;
			seg_word_q <= 1'b0;
			right_word_q <= 1'b0;
			wrap_q <= 1'b0;
			pend_q <= PEND_NONE;
		end else if (accept) begin
			pos_q <= n_pos;
			left_end_q <= n_left_end;
			right_end_q <= n_right_end;
			seg_begin_q <= n_seg_begin;
			lb_q <= n_lb;
			left_q <= n_left;
			right_q <= n_right;
			seg_word_q <= n_seg_word;
			right_word_q <= n_right_word;
			wrap_q <= n_wrap;
			pend_q <= n_pend;
		end
	end

endmodule

>>> sv/wbs_queue.sv
module wbs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wbs_pkg::entry_t     push_entry,
	input  logic                pop,
	output wbs_pkg::entry_t     head,
	output wbs_pkg::q_stat_t    q_stat
);

	localparam logic [wbs_pkg::QPTR_W:0] DEPTH = (wbs_pkg::QPTR_W + 1)'(wbs_pkg::QUEUE_DEPTH);

	wbs_pkg::entry_t              mem_q [wbs_pkg::QUEUE_DEPTH];
	logic [wbs_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [wbs_pkg::QPTR_W:0]     count_q;

	assign head = mem_q[rd_ptr_q];
	assign q_stat.full = (count_q == DEPTH);
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> sv/wbs_back.sv
module wbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wbs_pkg::entry_t               head,
	input  wbs_pkg::q_stat_t              q_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wbs_pkg::OUT_W-1:0]     segment_start,
	output logic [wbs_pkg::OUT_W-1:0]     segment_end,
	output logic                          is_word,
	output logic                          last_segment,
	output logic                          index_wrapped
);

	logic [wbs_pkg::SLOT_W-1:0] slot_q;
	logic                       out_valid_q;
	wbs_pkg::seg_t              seg_q;
	logic                       load;

	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	// retire the queue entry with its last result
	assign pop = load && (slot_q == head.count - 1'b1);

	always_ff @(posedge clk) begin
		if (load) seg_q <= head.seg[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) slot_q <= '0;
			else if (load) slot_q <= slot_q + 1'b1;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign segment_start = seg_q.start_idx;
	assign segment_end = seg_q.end_idx;
	assign is_word = seg_q.word;
	assign last_segment = seg_q.last;
	assign index_wrapped = seg_q.wrapped;

endmodule

>>> sv/word_boundary_segmenter.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | word_class, starts_word, end_of_text
// out     | output    | out_valid / out_ready | segment_start, segment_end, is_word,
//         |           |                       | last_segment, index_wrapped
//
// One item per cycle while out_ready stays high and each item yields at most
// one segment; an item that yields more (up to 3, at end of text) sends them
// out one after another, through the result queue and then the output register.
// A 4-entry result queue separates the classifier from the output register, so
// in_ready drops only when that queue is full; out_ready stalls reach the input
// only once they have filled the queue.
// Reset is asynchronous; after it the next item starts a text at index 0.
module word_boundary_segmenter #(
	parameter int INDEX_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [4:0]                    word_class,
	input  logic                          starts_word,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wbs_pkg::OUT_W-1:0]     segment_start,
	output logic [wbs_pkg::OUT_W-1:0]     segment_end,
	output logic                          is_word,
	output logic                          last_segment,
	output logic                          index_wrapped
);

	wbs_pkg::q_stat_t q_stat;
	wbs_pkg::entry_t  push_entry, head;
	logic             push, pop;

	wbs_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.word_class  (word_class),
		.starts_word (starts_word),
		.end_of_text (end_of_text),
		.q_stat      (q_stat),
		.push        (push),
		.push_entry  (push_entry)
	);

	wbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	wbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_start (segment_start),
		.segment_end   (segment_end),
		.is_word       (is_word),
		.last_segment  (last_segment),
		.index_wrapped (index_wrapped)
	);

endmodule

>>> sv/wbs_checker.sv
module wbs_checker #(
	parameter int INDEX_BITS = 20
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wbs_pkg::OUT_W-1:0]     segment_start,
	input logic [wbs_pkg::OUT_W-1:0]     segment_end,
	input logic                          index_wrapped,
	input logic                          last_segment
);

	localparam int MASK_BITS = (INDEX_BITS < wbs_pkg::OUT_W) ? INDEX_BITS : wbs_pkg::OUT_W;
	localparam logic [wbs_pkg::OUT_W:0] MASK_WIDE = (wbs_pkg::OUT_W + 1)'(1) << MASK_BITS;
	localparam logic [wbs_pkg::OUT_W-1:0] IDX_MASK = wbs_pkg::OUT_W'(MASK_WIDE - 1'b1);

	logic [wbs_pkg::OUT_W-1:0] exp_start_q;
	logic                      wrap_seen_q;
	logic                      out_acc;

	assign out_acc = out_valid && out_ready;

	// segments of a text tile the index range with no gap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_start_q <= '0;
			wrap_seen_q <= 1'b0;
		end else if (out_acc) begin
			exp_start_q <= last_segment ? '0 : ((segment_end + 1'b1) & IDX_MASK);
			wrap_seen_q <= index_wrapped && !last_segment;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_start)
			&& $stable(segment_end) && $stable(last_segment))
		else $error("output item changed while stalled");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> segment_start == exp_start_q)
		else $error("segment does not follow the previous one");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wrap_seen_q |-> index_wrapped)
		else $error("wrap flag dropped within a text");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_wrapped && (INDEX_BITS <= wbs_pkg::OUT_W)
			|-> segment_start <= segment_end)
		else $error("segment ends before it starts");

endmodule

bind word_boundary_segmenter wbs_checker #(.INDEX_BITS(INDEX_BITS)) u_wbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.segment_start (segment_start),
	.segment_end   (segment_end),
	.index_wrapped (index_wrapped),
	.last_segment  (last_segment)
);

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

	// Narrow index
	localparam int IDX_W = 8;
	localparam logic [31:0] IDX_MASK = (32'd1 << IDX_W) - 32'd1;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM = 145;
	localparam int HOLD_OFF_CYCLES = 80;

	typedef enum logic [4:0] {
		WB_OTHER     = 5'd0,
		WB_CR        = 5'd1,
		WB_LF        = 5'd2,
		WB_NEWLINE   = 5'd3,
		WB_EXTEND    = 5'd4,
		WB_FORMAT    = 5'd5,
		WB_KATAKANA  = 5'd6,
		WB_ALETTER   = 5'd7,
		WB_HEBREW    = 5'd8,
		WB_MIDLETTER = 5'd9,
		WB_MIDNUM    = 5'd10,
		WB_MIDNUMLET = 5'd11,
		WB_SQUOTE    = 5'd12,
		WB_DQUOTE    = 5'd13,
		WB_NUMERIC   = 5'd14,
		WB_EXTNUMLET = 5'd15,
		WB_REGIONAL  = 5'd16,
		WB_SOT       = 5'd17,
		WB_EOT       = 5'd18,
		WB_NONE      = 5'd19,
		WB_LEAD      = 5'd20
	} wb_class_e;

	localparam logic [4:0] WB_UNKNOWN_LO = 5'd17;
	localparam logic [4:0] WB_UNKNOWN_HI = 5'd31;

	typedef struct {
		logic [4:0]      cls;
		logic            sw;
		logic            eot;
		logic            known;
		wbs_pkg::seg_t   seg;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [4:0]  word_class;
	logic        starts_word;
	logic        end_of_text;
	logic        out_valid;
	logic        out_ready;
	logic [wbs_pkg::OUT_W-1:0] segment_start;
	logic [wbs_pkg::OUT_W-1:0] segment_end;
	logic        is_word;
	logic        last_segment;
	logic        index_wrapped;

	word_boundary_segmenter #(
		.INDEX_BITS(IDX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.word_class(word_class),
		.starts_word(starts_word),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.segment_start(segment_start),
		.segment_end(segment_end),
		.is_word(is_word),
		.last_segment(last_segment),
		.index_wrapped(index_wrapped)
	);

	// predictor state
	logic [31:0] pos_count, left_end, right_end, seg_begin;
	logic [4:0]  behind_cls, left_cls, right_cls;
	logic [1:0]  units_held;
	logic        seg_word, right_word, wrap_seen;

	wbs_pkg::seg_t pending_segs[$];
	stim_row_t dir_rows[N_DIRECTED];

	int err_count = 0;
	int items_sent = 0;
	int segs_checked = 0;
	int texts_sent = 0;
	int wrapped_segs = 0;
	int in_stalls = 0;
	bit burst_mode = 0;
	bit held_once = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic bit is_letter(input logic [4:0] c);
		return c == WB_ALETTER || c == WB_HEBREW;
	endfunction

	function automatic bit is_break_line(input logic [4:0] c);
		return c == WB_CR || c == WB_LF || c == WB_NEWLINE;
	endfunction

	function automatic bit is_midlet_q(input logic [4:0] c);
		return c == WB_MIDNUMLET || c == WB_SQUOTE;
	endfunction

	function automatic bit is_enl_mate(input logic [4:0] c);
		return is_letter(c) || c == WB_NUMERIC || c == WB_KATAKANA || c == WB_EXTNUMLET;
	endfunction

	// 1 when the units l and r stay in one segment
	function automatic bit no_break(input logic [4:0] lb, input logic [4:0] l,
			input logic [4:0] r, input logic [4:0] la);
		if (l == WB_CR && r == WB_LF) return 1;
		if (is_break_line(l) || is_break_line(r)) return 0;
		if (is_letter(l) && is_letter(r)) return 1;
		if (is_letter(l) && (r == WB_MIDLETTER || is_midlet_q(r)) && is_letter(la)) return 1;
		if (is_letter(lb) && (l == WB_MIDLETTER || is_midlet_q(l)) && is_letter(r)) return 1;
		if (l == WB_HEBREW && r == WB_SQUOTE) return 1;
		if (l == WB_HEBREW && r == WB_DQUOTE && la == WB_HEBREW) return 1;
		if (lb == WB_HEBREW && l == WB_DQUOTE && r == WB_HEBREW) return 1;
		if (l == WB_NUMERIC && r == WB_NUMERIC) return 1;
		if (is_letter(l) && r == WB_NUMERIC) return 1;
		if (l == WB_NUMERIC && is_letter(r)) return 1;
		if (lb == WB_NUMERIC && (l == WB_MIDNUM || is_midlet_q(l)) && r == WB_NUMERIC)
			return 1;
		if (l == WB_NUMERIC && (r == WB_MIDNUM || is_midlet_q(r)) && la == WB_NUMERIC)
			return 1;
		if (l == WB_KATAKANA && r == WB_KATAKANA) return 1;
		if (is_enl_mate(l) && r == WB_EXTNUMLET) return 1;
		if (l == WB_EXTNUMLET && is_enl_mate(r)) return 1;
		if (l == WB_REGIONAL && r == WB_REGIONAL) return 1;
		return 0;
	endfunction

	task automatic clear_text_state();
		pos_count = '0;
		left_end = '0;
		right_end = '0;
		seg_begin = '0;
		behind_cls = WB_SOT;
		left_cls = WB_SOT;
		right_cls = WB_NONE;
		units_held = '0;
		seg_word = 1'b0;
		right_word = 1'b0;
		wrap_seen = 1'b0;
	endtask

	task automatic push_seg(input logic [31:0] s, input logic [31:0] e, input logic w,
			input logic last);
		wbs_pkg::seg_t seg;
		seg.start_idx = s[wbs_pkg::OUT_W-1:0];
		seg.end_idx = e[wbs_pkg::OUT_W-1:0];
		seg.word = w;
		seg.last = last;
		seg.wrapped = wrap_seen;
		pending_segs.push_back(seg);
	endtask

	task automatic predict_segments(input logic [4:0] cls_in, input logic sw, input logic eot);
		logic [4:0]  cls;
		logic [31:0] p;
		cls = (cls_in > WB_REGIONAL) ? WB_OTHER : cls_in;
		p = pos_count & IDX_MASK;
		if (cls == WB_EXTEND || cls == WB_FORMAT) begin
			// folds into the unit before; at text start it opens a leading run
			if (units_held == 2'd0) begin
				if (left_cls != WB_LEAD) begin
					seg_word = sw;
					seg_begin = p;
					left_cls = WB_LEAD;
				end
			end else if (units_held == 2'd1) begin
				left_end = p;
			end else begin
				right_end = p;
			end
		end else if (units_held == 2'd0) begin
			if (left_cls != WB_LEAD) begin
				seg_word = sw;
				seg_begin = p;
			end
			behind_cls = WB_SOT;
			left_cls = cls;
			left_end = p;
			units_held = 2'd1;
		end else if (units_held == 2'd1) begin
			right_cls = cls;
			right_end = p;
			right_word = sw;
			units_held = 2'd2;
		end else begin
			if (!no_break(behind_cls, left_cls, right_cls, cls)) begin
				push_seg(seg_begin, left_end, seg_word, 1'b0);
				seg_begin = (left_end + 32'd1) & IDX_MASK;
				seg_word = right_word;
				behind_cls = WB_SOT;
			end else begin
				behind_cls = left_cls;
			end
			left_cls = right_cls;
			left_end = right_end;
			right_cls = cls;
			right_end = p;
			right_word = sw;
		end

		if (eot) begin
			if (units_held == 2'd0) begin
				push_seg(seg_begin, p, seg_word, 1'b1);
			end else if (units_held == 2'd1) begin
				push_seg(seg_begin, left_end, seg_word, 1'b1);
			end else if (!no_break(behind_cls, left_cls, right_cls, WB_EOT)) begin
				push_seg(seg_begin, left_end, seg_word, 1'b0);
				push_seg((left_end + 32'd1) & IDX_MASK, right_end, right_word, 1'b1);
			end else begin
				push_seg(seg_begin, right_end, seg_word, 1'b1);
			end
			clear_text_state();
		end else begin
			pos_count = (p + 32'd1) & IDX_MASK;
			if (pos_count == 32'd0)
				wrap_seen = 1'b1;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly letters, digits and their joiners so that the multi-unit rules fire
	function automatic logic [4:0] pick_class();
		int r;
		r = $urandom_range(0, 99);
		if (r < 24) return WB_ALETTER;
		if (r < 33) return WB_HEBREW;
		if (r < 47) return WB_NUMERIC;
		if (r < 59) return 5'($urandom_range(WB_MIDLETTER, WB_DQUOTE));
		if (r < 67) return ($urandom_range(0, 1) != 0) ? WB_EXTEND : WB_FORMAT;
		if (r < 73) return WB_KATAKANA;
		if (r < 78) return WB_EXTNUMLET;
		if (r < 84) return WB_REGIONAL;
		if (r < 90) return 5'($urandom_range(WB_CR, WB_NEWLINE));
		if (r < 95) return WB_OTHER;
		return 5'($urandom_range(WB_UNKNOWN_LO, WB_UNKNOWN_HI));
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [4:0] cls, input logic sw, input logic eot,
			input logic known, input wbs_pkg::seg_t typed);
		int gap;
		int n_before;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		word_class = cls;
		starts_word = sw;
		end_of_text = eot;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		n_before = pending_segs.size();
		predict_segments(cls, sw, eot);
		if (known) begin
			while (pending_segs.size() > n_before)
				void'(pending_segs.pop_back());
			pending_segs.push_back(typed);
		end
		items_sent++;
		if (eot)
			texts_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk)
		if (arst_n && in_valid && !in_ready)
			in_stalls++;

	always @(posedge clk) begin : seg_check
		wbs_pkg::seg_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_segs.size() == 0) begin
				$error("unexpected segment %0d..%0d", segment_start, segment_end);
				err_count++;
			end else begin
				want = pending_segs.pop_front();
				segs_checked++;
				if (index_wrapped)
					wrapped_segs++;
				if (segment_start !== want.start_idx) begin
					$error("segment_start: expected %0d, got %0d", want.start_idx,
						segment_start);
					err_count++;
				end
				if (segment_end !== want.end_idx) begin
					$error("segment_end: expected %0d, got %0d", want.end_idx, segment_end);
					err_count++;
				end
				if (is_word !== want.word) begin
					$error("is_word: expected %0b, got %0b", want.word, is_word);
					err_count++;
				end
				if (last_segment !== want.last) begin
					$error("last_segment: expected %0b, got %0b", want.last, last_segment);
					err_count++;
				end
				if (index_wrapped !== want.wrapped) begin
					$error("index_wrapped: expected %0b, got %0b", want.wrapped,
						index_wrapped);
					err_count++;
				end
			end
		end
	end

	// receiver: random stalls, always-ready stretches, and one long hold-off
	initial begin : sink
		int stall_left;
		int open_left;
		int r;
		stall_left = 0;
		open_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && items_sent >= 120) begin
				held_once = 1;
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else if (open_left > 0) begin
				out_ready = 1'b1;
				open_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				out_ready = 1'b1;
				if (r < 8) begin
					open_left = 40;
				end else if (r < 25) begin
					out_ready = 1'b0;
					stall_left = $urandom_range(0, 2);
				end else if (r < 29) begin
					out_ready = 1'b0;
					stall_left = $urandom_range(8, 30);
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("word_boundary_segmenter test failed");
		$finish;
	end

	initial begin : stimulus
		int n_random;
		int len;
		logic [4:0] cls;
		wbs_pkg::seg_t none_seg;

		none_seg = '0;
		dir_rows[0]  = '{WB_OTHER,      1'b1, 1'b1, 1'b1, '{20'd0, 20'd0, 1'b1, 1'b1, 1'b0}};
		dir_rows[1]  = '{WB_UNKNOWN_HI, 1'b0, 1'b1, 1'b1, '{20'd0, 20'd0, 1'b0, 1'b1, 1'b0}};
		// a text of nothing but Extend and Format is one segment
		dir_rows[2]  = '{WB_EXTEND,     1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[3]  = '{WB_FORMAT,     1'b0, 1'b1, 1'b1, '{20'd0, 20'd1, 1'b1, 1'b1, 1'b0}};
		dir_rows[4]  = '{WB_CR,         1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[5]  = '{WB_LF,         1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[6]  = '{WB_NEWLINE,    1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[7]  = '{WB_FORMAT,     1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[8]  = '{WB_ALETTER,    1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[9]  = '{WB_MIDLETTER,  1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[10] = '{WB_HEBREW,     1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[11] = '{WB_DQUOTE,     1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[12] = '{WB_HEBREW,     1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[13] = '{WB_SQUOTE,     1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[14] = '{WB_NUMERIC,    1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[15] = '{WB_MIDNUM,     1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[16] = '{WB_NUMERIC,    1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[17] = '{WB_MIDNUMLET,  1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[18] = '{WB_KATAKANA,   1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[19] = '{WB_KATAKANA,   1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[20] = '{WB_EXTNUMLET,  1'b1, 1'b0, 1'b0, none_seg};
		dir_rows[21] = '{WB_REGIONAL,   1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[22] = '{WB_REGIONAL,   1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[23] = '{WB_EXTEND,     1'b0, 1'b0, 1'b0, none_seg};
		dir_rows[24] = '{WB_OTHER,      1'b0, 1'b1, 1'b0, none_seg};

		arst_n = 1'b0;
		in_valid = 1'b0;
		word_class = '0;
		starts_word = 1'b0;
		end_of_text = 1'b0;
		clear_text_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cls, dir_rows[i].sw, dir_rows[i].eot, dir_rows[i].known,
				dir_rows[i].seg);

		n_random = 0;
		while (n_random < N_RANDOM) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(15, 40);
			else
				len = $urandom_range(1, 10);
			for (int j = 0; j < len; j++) begin
				cls = pick_class();
				send_item(cls, 1'($urandom_range(0, 1)), 1'(j == len - 1), 1'b0, none_seg);
			end
			n_random += len;
		end
		in_valid = 1'b0;
		end_of_text = 1'b0;

		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d code points in %0d texts, %0d segments checked (%0d wrapped)",
			items_sent, texts_sent, segs_checked, wrapped_segs);
		$display("input held back by a full result queue for %0d cycles", in_stalls);
		if (err_count == 0)
			$display("word_boundary_segmenter test passed");
		else
			$display("word_boundary_segmenter test failed");
		$finish;
	end

endmodule

>>> files.f
sv/wbs_pkg.sv
sv/wbs_front.sv
sv/wbs_queue.sv
sv/wbs_back.sv
sv/word_boundary_segmenter.sv
sv/wbs_checker.sv
dv/tb.sv
